// ===== rtl/crm_pkg.sv =====
// Shared constants, codes and types of the chained interval remap block.
// No dependencies; every other file of the block depends on this package.
package crm_pkg;

  localparam int STAGES     = 7;
  localparam int RULES      = 64;
  localparam int VALUE_BITS = 48;

  // Fixed widths of the channel fields.
  localparam int ACT_W   = 2;
  localparam int STAGE_W = 3;
  localparam int SLOT_W  = 6;
  localparam int DATA_W  = 48;

  localparam int TOTAL_RULES = STAGES * RULES;
  localparam int ADDR_W      = (TOTAL_RULES > 1) ? $clog2(TOTAL_RULES) : 1;
  localparam int RULE_IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int RULE_CNT_W  = $clog2(RULES + 1);
  localparam int STG_W       = (STAGES > 1) ? $clog2(STAGES) : 1;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MAP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef struct packed {
    logic   valid;
    value_t dest;
    value_t src;
    value_t len;
  } rule_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    rule_t data;
  } mem_wr_t;

  typedef struct packed {
    logic   hit;
    value_t mapped;
  } match_t;

endpackage

// ===== rtl/crm_in_if.sv =====
// Input channel of the chained interval remap block: valid/ready plus item fields.
// Depends on crm_pkg for the field widths.
interface crm_in_if;
  logic                           valid;
  logic                           ready;
  logic [crm_pkg::ACT_W-1:0]      action;
  logic [crm_pkg::STAGE_W-1:0]    stage;
  logic [crm_pkg::SLOT_W-1:0]     slot;
  logic                           rule_enable;
  logic [crm_pkg::DATA_W-1:0]     dest_start;
  logic [crm_pkg::DATA_W-1:0]     src_start;
  logic [crm_pkg::DATA_W-1:0]     span_length;
  logic [crm_pkg::DATA_W-1:0]     value;

  modport source (
    output valid, action, stage, slot, rule_enable, dest_start, src_start,
           span_length, value,
    input  ready
  );
  modport sink (
    input  valid, action, stage, slot, rule_enable, dest_start, src_start,
           span_length, value,
    output ready
  );
endinterface

// ===== rtl/crm_out_if.sv =====
// Result channel of the chained interval remap block: valid/ready plus result fields.
// Depends on crm_pkg for the field widths.
interface crm_out_if;
  logic                       valid;
  logic                       ready;
  logic [crm_pkg::DATA_W-1:0] location;
  logic [crm_pkg::DATA_W-1:0] best_location;
  logic [crm_pkg::DATA_W-1:0] best_seed;

  modport source (output valid, location, best_location, best_seed, input ready);
  modport sink   (input  valid, location, best_location, best_seed, output ready);
endinterface

// ===== rtl/chained_interval_remap_min.sv =====
// Top level of the chained interval remap block with minimum tracker.
// Depends on crm_pkg, crm_in_if, crm_out_if, crm_rule_mem and crm_match.
//
//   Channel  | Dir | Handshake   | Word
//   in_ch    | in  | valid/ready | action, stage, slot, rule_enable, dest/src/span, value
//   out_ch   | out | valid/ready | location, best_location, best_seed
//
// After reset the block sweeps all TOTAL_RULES (448) entries of the rule memory,
// clearing every valid mark, and is not ready during that sweep.
// A map word walks the stages in order: the single read port of the rule memory
// delivers one rule per cycle, and each stage first waits for its first
// registered read. The read still in flight when a rule hits is dropped.
// The result sits in an output register, so new words are taken while it
// waits; a map finishing while the register is still full waits for it.
module chained_interval_remap_min (
  input logic   clk,
  input logic   rst_n,
  crm_in_if.sink    in_ch,
  crm_out_if.source out_ch
);
  import crm_pkg::*;

  typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                state_r, state_nxt;
  addr_t                 clr_addr_r, clr_addr_nxt;
  logic [STG_W-1:0]      stg_r, stg_nxt;
  logic [RULE_CNT_W-1:0] iss_r, iss_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  rd_last_r, rd_last_nxt;
  value_t                cur_r, cur_nxt;
  value_t                seed_r, seed_nxt;
  value_t                min_loc_r, min_loc_nxt;
  value_t                min_seed_r, min_seed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  value_t                out_loc_r, out_loc_nxt;
  value_t                out_best_r, out_best_nxt;
  value_t                out_seed_r, out_seed_nxt;

  mem_wr_t mem_wr;
  logic    mem_rd_en;
  addr_t   mem_rd_addr;
  rule_t   mem_rd_data;
  match_t  match;
  logic    in_acc;
  logic    new_min;

  crm_rule_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The one compare unit, reused for every rule of every stage.
  crm_match u_match (
    .value (cur_r),
    .rule  (mem_rd_data),
    .res   (match)
  );

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign in_acc               = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.location      = DATA_W'(out_loc_r);
  assign out_ch.best_location = DATA_W'(out_best_r);
  assign out_ch.best_seed     = DATA_W'(out_seed_r);
  assign new_min              = (cur_r < min_loc_r);
  assign mem_rd_addr          = addr_t'(int'(stg_r) * RULES + int'(iss_r[RULE_IDX_W-1:0]));

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    stg_nxt       = stg_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = rd_last_r;
    cur_nxt       = cur_r;
    seed_nxt      = seed_r;
    min_loc_nxt   = min_loc_r;
    min_seed_nxt  = min_seed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_loc_nxt   = out_loc_r;
    out_best_nxt  = out_best_r;
    out_seed_nxt  = out_seed_r;
    mem_rd_en     = 1'b0;
    mem_wr        = '0;

    unique case (state_r)
      ST_CLR: begin
        // Only the valid mark matters; the rest of the entry stays unused.
        mem_wr.we   = 1'b1;
        mem_wr.addr = clr_addr_r;
        if (clr_addr_r == addr_t'(TOTAL_RULES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.action)
            ACT_WRITE: begin
              // Writes aimed beyond the tables are dropped.
              if (int'(in_ch.stage) < STAGES && int'(in_ch.slot) < RULES) begin
                mem_wr.we         = 1'b1;
                mem_wr.addr       = addr_t'(int'(in_ch.stage) * RULES + int'(in_ch.slot));
                mem_wr.data.valid = in_ch.rule_enable;
                mem_wr.data.dest  = VALUE_BITS'(in_ch.dest_start);
                mem_wr.data.src   = VALUE_BITS'(in_ch.src_start);
                mem_wr.data.len   = VALUE_BITS'(in_ch.span_length);
              end
            end
            ACT_MAP: begin
              cur_nxt   = VALUE_BITS'(in_ch.value);
              seed_nxt  = VALUE_BITS'(in_ch.value);
              stg_nxt   = '0;
              iss_nxt   = '0;
              state_nxt = ST_RUN;
            end
            ACT_CLEAR: begin
              min_loc_nxt  = '1;
              min_seed_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        // Issue the next rule of this stage while the previous one is tested.
        if (int'(iss_r) < RULES) begin
          mem_rd_en   = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (iss_r == RULE_CNT_W'(RULES - 1));
          iss_nxt     = iss_r + 1'b1;
        end
        if (rd_vld_r && (match.hit || rd_last_r)) begin
          // Stage settled: drop any read in flight and start the next table, or finish after the last.
          if (match.hit) begin
            cur_nxt = match.mapped;
          end
          rd_vld_nxt = 1'b0;
          iss_nxt    = '0;
          if (stg_r == STG_W'(STAGES - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            stg_nxt = stg_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          // Ties keep the earlier seed; only a strictly smaller value wins.
          if (new_min) begin
            min_loc_nxt  = cur_r;
            min_seed_nxt = seed_r;
          end
          out_valid_nxt = 1'b1;
          out_loc_nxt   = cur_r;
          out_best_nxt  = new_min ? cur_r : min_loc_r;
          out_seed_nxt  = new_min ? seed_r : min_seed_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      min_loc_r   <= '1;
      min_seed_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      min_loc_r   <= min_loc_nxt;
      min_seed_r  <= min_seed_nxt;
      stg_r       <= stg_nxt;
      iss_r       <= iss_nxt;
      rd_last_r   <= rd_last_nxt;
      cur_r       <= cur_nxt;
      seed_r      <= seed_nxt;
      out_loc_r   <= out_loc_nxt;
      out_best_r  <= out_best_nxt;
      out_seed_r  <= out_seed_nxt;
    end
  end

  // A rule read is only in flight while a value walks the tables.
  a_rd_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == ST_RUN)
    else $error("rule read in flight outside of a map");

  // The stage counter never leaves the table range during a walk.
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> int'(stg_r) < STAGES)
    else $error("stage counter out of range");

  // The reported minimum can never exceed the value reported with it.
  a_best_le_loc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_best_r <= out_loc_r)
    else $error("best location above reported location");

  // Without a clear word the tracked minimum never grows.
  a_min_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_ch.action == ACT_CLEAR) |=> min_loc_r <= $past(min_loc_r))
    else $error("tracked minimum increased without a clear");

endmodule

// ===== rtl/crm_rule_mem.sv =====
// Rule memory: one entry per rule of every stage, one write and one read port.
// Read data is registered. Depends on crm_pkg.
module crm_rule_mem (
  input  logic             clk,
  input  crm_pkg::mem_wr_t wr,
  input  logic             rd_en,
  input  crm_pkg::addr_t   rd_addr,
  output crm_pkg::rule_t   rd_data
);
  import crm_pkg::*;

  rule_t mem [TOTAL_RULES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/crm_match.sv =====
// Shared compare and offset unit: tests one rule against a value and remaps it.
// Depends on crm_pkg.
module crm_match (
  input  crm_pkg::value_t value,
  input  crm_pkg::rule_t  rule,
  output crm_pkg::match_t res
);
  import crm_pkg::*;

  logic [VALUE_BITS:0] diff;

  // The borrow of value - src tells value < src; the interval never wraps.
  assign diff       = {1'b0, value} - {1'b0, rule.src};
  assign res.hit    = rule.valid && !diff[VALUE_BITS] && (diff[VALUE_BITS-1:0] < rule.len);
  assign res.mapped = diff[VALUE_BITS-1:0] + rule.dest;

endmodule

// ===== sim/remap_checker.sv =====
// Checker for the chained interval remap block: watches both channels, predicts every result.
// Depends on crm_pkg and on the crm_in_if and crm_out_if interfaces.
module remap_checker (
  input  logic        clk,
  input  logic        rst_n,
  crm_in_if           in_ch,
  crm_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned expected_left
);
  import crm_pkg::*;

  typedef struct packed {
    value_t location;
    value_t best_location;
    value_t best_seed;
  } map_result_t;

  // Private copy of the rule tables and of the minimum tracker.
  value_t tbl_dest [STAGES][RULES];
  value_t tbl_src  [STAGES][RULES];
  value_t tbl_len  [STAGES][RULES];
  bit     tbl_on   [STAGES][RULES];
  value_t low_location = '1;
  value_t low_seed     = '0;

  map_result_t predicted_maps[$];
  int unsigned errors = 0;

  // Walks the value through every stage; the lowest active rule that holds it wins.
  function automatic value_t chain_lookup(value_t seed);
    value_t v;
    v = seed;
    for (int s = 0; s < STAGES; s++) begin
      for (int r = 0; r < RULES; r++) begin
        if (tbl_on[s][r] && v >= tbl_src[s][r] && (v - tbl_src[s][r]) < tbl_len[s][r]) begin
          v = v + tbl_dest[s][r] - tbl_src[s][r];
          break;
        end
      end
    end
    return v;
  endfunction

  task automatic absorb_word();
    map_result_t res;
    value_t      seed;
    case (in_ch.action)
      ACT_WRITE: begin
        if (in_ch.stage < STAGES && in_ch.slot < RULES) begin
          tbl_on[in_ch.stage][in_ch.slot]   = in_ch.rule_enable;
          tbl_dest[in_ch.stage][in_ch.slot] = in_ch.dest_start;
          tbl_src[in_ch.stage][in_ch.slot]  = in_ch.src_start;
          tbl_len[in_ch.stage][in_ch.slot]  = in_ch.span_length;
        end
      end
      ACT_MAP: begin
        seed         = in_ch.value;
        res.location = chain_lookup(seed);
        // Only a strictly smaller location replaces the held minimum.
        if (res.location < low_location) begin
          low_location = res.location;
          low_seed     = seed;
        end
        res.best_location = low_location;
        res.best_seed     = low_seed;
        predicted_maps    = {predicted_maps, res};
      end
      ACT_CLEAR: begin
        low_location = '1;
        low_seed     = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string label, input value_t want, input value_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      low_location = '1;
      low_seed     = '0;
      for (int s = 0; s < STAGES; s++) begin
        for (int r = 0; r < RULES; r++) tbl_on[s][r] = 1'b0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_word();
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_maps.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h %h %h", $time,
                   out_ch.location, out_ch.best_location, out_ch.best_seed);
          errors++;
        end else begin
          want = predicted_maps.pop_front();
          check_field("location", want.location, out_ch.location);
          check_field("best_location", want.best_location, out_ch.best_location);
          check_field("best_seed", want.best_seed, out_ch.best_seed);
        end
      end
    end
    fail_count    <= errors;
    expected_left <= predicted_maps.size();
  end

endmodule

// ===== sim/chained_interval_remap_min_tb.sv =====
// Top of the testbench for the chained interval remap block: clock, reset, stimulus, verdict.
// Depends on crm_pkg, crm_in_if, crm_out_if, remap_checker and the block itself.
module chained_interval_remap_min_tb;
  import crm_pkg::*;

  // Action code that the block does not define; such a word must be dropped silently.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // The random part is split evenly over four idling phases.
  localparam int RANDOM_ITEMS = 1308;
  localparam int PHASES       = 4;
  // Long receiver hold-off, so that the result register fills and the input stalls.
  localparam int HOLD_CYCLES  = 2000;
  // The drain waits longer than the slowest map word needs.
  localparam int DRAIN_CYCLES = 500;
  // Quiet cycles tolerated: covers the clearing sweep after reset, the
  // slowest map, and the long hold-off, several times over.
  localparam int WATCHDOG_LIMIT = 12000;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [STAGE_W-1:0] stage;
    logic [SLOT_W-1:0]  slot;
    logic               rule_enable;
    value_t             dest_start;
    value_t             src_start;
    value_t             span_length;
    value_t             value;
  } in_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crm_in_if  in_ch();
  crm_out_if out_ch();

  int unsigned fail_count;
  int unsigned expected_left;

  // Idling knobs. The sender's knob is read only by the stimulus process itself;
  // the receiver's knob is changed with nonblocking assignments.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  // Source intervals of rules written active, used to aim map values at real hits.
  value_t hit_src[$];
  value_t hit_len[$];

  chained_interval_remap_min dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  remap_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always #5 clk = ~clk;

  // Every input of the block starts at a known value.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_CLEAR;
    in_ch.stage       = '0;
    in_ch.slot        = '0;
    in_ch.rule_enable = 1'b0;
    in_ch.dest_start  = '0;
    in_ch.src_start   = '0;
    in_ch.span_length = '0;
    in_ch.value       = '0;
    out_ch.ready      = 1'b0;
  end

  // Receiver. It stalls at random by the current percentage, and once, when the
  // stimulus asks for it, holds ready low for a long stretch that it counts itself.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left    <= HOLD_CYCLES - 1;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic value_t rand48();
    return value_t'({$urandom, $urandom});
  endfunction

  // Offers one word, after a random gap, and returns at the edge that accepts it.
  // The ready seen right after the edge is the value the block held at that edge.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= w.action;
    in_ch.stage       <= w.stage;
    in_ch.slot        <= w.slot;
    in_ch.rule_enable <= w.rule_enable;
    in_ch.dest_start  <= w.dest_start;
    in_ch.src_start   <= w.src_start;
    in_ch.span_length <= w.span_length;
    in_ch.value       <= w.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Fields that an action does not use still carry random bits.
  function automatic in_word_t noise_word(input logic [ACT_W-1:0] act);
    in_word_t w;
    w.action      = act;
    w.stage       = STAGE_W'($urandom);
    w.slot        = SLOT_W'($urandom);
    w.rule_enable = 1'($urandom);
    w.dest_start  = rand48();
    w.src_start   = rand48();
    w.span_length = rand48();
    w.value       = rand48();
    return w;
  endfunction

  task automatic put_rule(input logic [STAGE_W-1:0] stg, input logic [SLOT_W-1:0] slt,
                          input logic en, input value_t dst, input value_t src,
                          input value_t len);
    in_word_t w;
    w             = noise_word(ACT_WRITE);
    w.stage       = stg;
    w.slot        = slt;
    w.rule_enable = en;
    w.dest_start  = dst;
    w.src_start   = src;
    w.span_length = len;
    if (en && stg < STAGES) begin
      hit_src = {hit_src, src};
      hit_len = {hit_len, len};
    end
    send_word(w);
  endtask

  task automatic map_value(input value_t v);
    in_word_t w;
    w       = noise_word(ACT_MAP);
    w.value = v;
    send_word(w);
  endtask

  task automatic clear_min();
    send_word(noise_word(ACT_CLEAR));
  endtask

  task automatic send_unused();
    send_word(noise_word(ACT_UNUSED));
  endtask

  // Random rule: half are small overlapping intervals in a narrow range, so that a
  // value hops through several stages; the rest covers the full field range,
  // intervals that run past the top, and empty intervals. Stage 7 writes are dropped.
  task automatic random_rule();
    int                 pick;
    logic [STAGE_W-1:0] stg;
    logic [SLOT_W-1:0]  slt;
    logic               en;
    value_t             dst;
    value_t             src;
    value_t             len;
    pick = $urandom_range(99, 0);
    stg  = STAGE_W'($urandom_range(7, 0));
    slt  = $urandom_range(1, 0) ? SLOT_W'($urandom_range(7, 0)) : SLOT_W'($urandom_range(63, 0));
    en   = ($urandom_range(99, 0) < 85);
    if (pick < 50) begin
      dst = value_t'($urandom_range(4095, 0));
      src = value_t'($urandom_range(4095, 0));
      len = value_t'($urandom_range(700, 0));
    end else if (pick < 60) begin
      dst = rand48();
      src = '1 - value_t'($urandom_range(4095, 0));
      len = rand48();
    end else if (pick < 68) begin
      dst = value_t'($urandom_range(4095, 0));
      src = value_t'($urandom_range(4095, 0));
      len = '0;
    end else begin
      dst = rand48();
      src = rand48();
      len = rand48() >> $urandom_range(47, 0);
    end
    put_rule(stg, slt, en, dst, src, len);
  endtask

  // Random map value: most fall inside an interval written earlier.
  task automatic random_map();
    int          pick;
    int          idx;
    logic [63:0] wide;
    value_t      v;
    pick = $urandom_range(99, 0);
    wide = {$urandom, $urandom};
    if (pick < 60 && hit_src.size() != 0) begin
      idx = $urandom_range(hit_src.size() - 1, 0);
      if (hit_len[idx] == 0) begin
        v = hit_src[idx];
      end else begin
        v = hit_src[idx] + value_t'(wide % hit_len[idx]);
      end
    end else if (pick < 90) begin
      v = value_t'($urandom_range(4095, 0));
    end else begin
      v = rand48();
    end
    map_value(v);
  endtask

  initial begin
    int sent;
    int pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with no idling. Empty tables pass values through unchanged,
    // and the extremes of the value range go through first.
    map_value('0);
    map_value('1);
    clear_min();
    // An all-ones location ties with the freshly cleared minimum and must not replace it.
    map_value('1);
    // A rule written inactive stores its data but never matches.
    put_rule(0, 0, 1'b0, 100, 0, 10);
    map_value(5);
    put_rule(0, 0, 1'b1, 100, 0, 10);
    // Overlapping rule in a higher slot: the lower slot wins where both hold the value.
    put_rule(0, 1, 1'b1, 200, 0, 20);
    map_value(5);
    map_value(15);
    // An empty interval never matches.
    put_rule(1, 0, 1'b1, 0, 100, 0);
    map_value(5);
    // Interval whose nominal end lies beyond the top of the value range.
    put_rule(6, 63, 1'b1, 0, '1 - 4, '1);
    map_value('1);
    map_value('1 - 5);
    // A write to a stage that does not exist is dropped.
    put_rule(7, 0, 1'b1, 0, 0, '1);
    map_value(3);
    // Destination near the top: the sum wraps around.
    put_rule(3, 0, 1'b1, '1, 1000, 10);
    clear_min();
    map_value(1005);
    // Same location again from a later input: the earlier input stays the best seed.
    map_value('1);
    send_unused();
    map_value(1000);

    // Random part, one idling setting per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          src_idle_pct   = 58;
          sink_stall_pct <= 0;
        end
        2: begin
          // The sender keeps offering words while the receiver holds off.
          src_idle_pct   = 0;
          sink_stall_pct <= 58;
          hold_req       <= 1'b1;
        end
        default: begin
          src_idle_pct   = 37;
          sink_stall_pct <= 37;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        pick = $urandom_range(99, 0);
        if (pick < 38) begin
          random_rule();
          sent++;
        end else if (pick < 93) begin
          random_map();
          sent++;
        end else if (pick < 97) begin
          clear_min();
          sent++;
        end else begin
          send_unused();
        end
      end
    end

    // Let every outstanding result come out, then watch a little longer for strays.
    // The count is sampled once the checker has registered the last accepted word, so that it includes that word.
    in_ch.valid    <= 1'b0;
    sink_stall_pct <= 0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
